// ===== hw/rtl/pcbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_pkg: shared types and constants of the point cloud box normalizer
// Request and status codes, queue entry format and arithmetic widths used by
// the front, back and divider modules.
// ----------------------------------------------------------------------------
package pcbn_pkg;

  localparam int COORD_W  = 32;
  localparam int AXES     = 3;
  localparam int AXIS_W   = 2;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_MEASURE = 2'd1;
  localparam logic [1:0] REQ_NORM    = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SAT   = 2'd1;
  localparam logic [1:0] STAT_DEGEN = 2'd2;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [31:0] TARGET_SCALE_RST = 32'd655360;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Scale factor divider: (target_scale << 16) / extent, one bit per cycle.
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Magnitude of 2*coord - (min + max) and the split used by the multiplier.
  localparam int MAG_W  = 34;
  localparam int HALF_W = 17;
  localparam int PP_W   = HALF_W + 32;
  localparam int PROD_W = PP_W + HALF_W;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_NORM    = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ===== hw/rtl/point_cloud_box_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_box_normalizer: bounding box center and scale normalization
// Measures a point cloud's axis-aligned box, then centers and scales points.
// ----------------------------------------------------------------------------
// Usage. Each input transaction carries a request code and a signed Q16.16
// point. Clear resets the box, measure widens it, and normalize returns the
// point moved to the box middle and scaled so the largest extent maps to
// cfg_target_scale. Only normalize produces an output transaction; reserved
// request codes are taken and dropped.
// Operation. A command queue in front lets the input side keep moving while
// the back end works. The back end runs one command at a time: clear and
// measure are applied as they leave the queue, and a normalize with a known
// scale factor takes each axis through difference, low and high partial
// products on the shared split multiplier and accumulation, then loads the
// output register. The first normalize after a box or register change also
// runs the extent search and, for a nondegenerate box, the bit-serial divider.
// Reset clears the queue, the output register and the scale factor, sets the
// box to empty and the target scale to 10.0. When the receiver stalls, the
// output register holds its transaction, the back end waits with the next
// result, and the queue fills until in_stall rises.
// ----------------------------------------------------------------------------
module point_cloud_box_normalizer
  import pcbn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_target_scale,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic signed [COORD_W-1:0] in_z_coord,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [1:0]                out_status
);

  entry_t q_head;
  qstat_t q_st;
  logic   q_pop;

  // Front end: accepts transactions and queues classified commands.
  pcbn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_x_coord  (in_x_coord),
    .in_y_coord  (in_y_coord),
    .in_z_coord  (in_z_coord),
    .head        (q_head),
    .q_st        (q_st),
    .q_pop       (q_pop)
  );

  // Back end: box state, scale factor divider, multiplier and output register.
  pcbn_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_target_scale (cfg_target_scale),
    .head             (q_head),
    .q_st             (q_st),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_status       (out_status)
  );

  // The back end only takes commands that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("command taken from an empty queue");

  // A degenerate box always reports a zero point.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_DEGEN) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("degenerate result with nonzero coordinates");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== hw/rtl/pcbn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_front: input acceptance and command queue
// Takes input transactions, turns the request code into a queue command and
// drops reserved codes. Holds up to QDEPTH commands for the back end.
// ----------------------------------------------------------------------------
module pcbn_front
  import pcbn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic signed [COORD_W-1:0] in_z_coord,
  output entry_t                    head,
  output qstat_t                    q_st,
  input  logic                      q_pop
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                do_pop;
  entry_t              new_entry;

  assign q_st.empty = (count_r == '0);
  assign q_st.full  = (count_r == QCNT_W'(QDEPTH));
  assign in_stall   = q_st.full;

  // Reserved request codes are taken but never queued.
  assign push   = in_valid && !q_st.full && (in_req_type != REQ_RSVD);
  assign do_pop = q_pop && !q_st.empty;

  always_comb begin
    new_entry.x = in_x_coord;
    new_entry.y = in_y_coord;
    new_entry.z = in_z_coord;
    case (in_req_type)
      REQ_CLEAR:   new_entry.op = OP_CLEAR;
      REQ_MEASURE: new_entry.op = OP_MEASURE;
      REQ_NORM:    new_entry.op = OP_NORM;
      default:     new_entry.op = OP_CLEAR;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_entry;
    end
  end

  assign head = mem[rd_ptr_r];

endmodule

// ===== hw/rtl/pcbn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_div: radix-2 restoring divider
// Unsigned DIV_W-bit dividend by 32-bit divisor, one quotient bit per cycle.
// done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module pcbn_div
  import pcbn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [32:0]          shifted;
  logic [32:0]          trial;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so 32 bits hold it.
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/pcbn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_back: command execution for the box normalizer
// Owns the bounding box, scale factor and target scale register. Runs one
// queued command at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module pcbn_back
  import pcbn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_target_scale,
  input  entry_t                    head,
  input  qstat_t                    q_st,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [1:0]                out_status
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXT  = 9'b000000010,
    ST_BIG  = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_DIFF = 9'b000010000,
    ST_MLO  = 9'b000100000,
    ST_MHI  = 9'b001000000,
    ST_ACC  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } bstate_t;

  bstate_t                   state_r, state_nxt;
  logic [31:0]               tscale_r, tscale_nxt;
  logic signed [COORD_W-1:0] box_min_r [AXES];
  logic signed [COORD_W-1:0] box_min_nxt [AXES];
  logic signed [COORD_W-1:0] box_max_r [AXES];
  logic signed [COORD_W-1:0] box_max_nxt [AXES];
  logic [31:0]               sf_r, sf_nxt;
  logic                      ready_r, ready_nxt;
  logic signed [COORD_W-1:0] cur_r [AXES];
  logic signed [COORD_W-1:0] cur_nxt [AXES];
  logic signed [COORD_W:0]   ext_r [AXES];
  logic signed [COORD_W:0]   ext_nxt [AXES];
  logic [AXIS_W-1:0]         axis_r, axis_nxt;
  logic                      neg_r, neg_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic [PP_W-1:0]           plo_r, plo_nxt;
  logic [PP_W-1:0]           phi_r, phi_nxt;
  logic [COORD_W-1:0]        res_r [AXES];
  logic [COORD_W-1:0]        res_nxt [AXES];
  logic                      sat_any_r, sat_any_nxt;
  logic [1:0]                stat_r, stat_nxt;
  logic                      ov_r, ov_nxt;
  logic [COORD_W-1:0]        ox_r, ox_nxt;
  logic [COORD_W-1:0]        oy_r, oy_nxt;
  logic [COORD_W-1:0]        oz_r, oz_nxt;
  logic [1:0]                ost_r, ost_nxt;

  logic signed [COORD_W-1:0] hc [AXES];
  logic signed [COORD_W:0]   big;
  logic signed [COORD_W+2:0] diff;
  logic signed [COORD_W+2:0] diff_neg;
  logic [PROD_W-1:0]         prod;
  logic                      prod_sat;
  logic [COORD_W-1:0]        up_mag;
  logic [COORD_W-1:0]        ax_val;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;

  assign hc[0] = head.x;
  assign hc[1] = head.y;
  assign hc[2] = head.z;

  // Largest extent over the three axes.
  always_comb begin
    big = ext_r[0];
    if (ext_r[1] > big) begin
      big = ext_r[1];
    end
    if (ext_r[2] > big) begin
      big = ext_r[2];
    end
  end

  // Twice the distance from the box middle, kept exact.
  assign diff = ($signed({{2{cur_r[axis_r][COORD_W-1]}}, cur_r[axis_r], 1'b0}))
              - ($signed({{3{box_min_r[axis_r][COORD_W-1]}}, box_min_r[axis_r]}))
              - ($signed({{3{box_max_r[axis_r][COORD_W-1]}}, box_max_r[axis_r]}));
  assign diff_neg = -diff;

  // Full product |d| * factor; anything at or above 2^48 clamps.
  assign prod     = {phi_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_r};
  assign prod_sat = |prod[PROD_W-1:48];
  // Rounded toward minus infinity: ceil of the magnitude for negative values.
  assign up_mag   = {1'b0, prod[47:HALF_W]} + {31'd0, (|prod[HALF_W-1:0])};

  always_comb begin
    if (prod_sat) begin
      ax_val = neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      ax_val = ~up_mag + 1'b1;
    end else begin
      ax_val = {1'b0, prod[47:HALF_W]};
    end
  end

  pcbn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({tscale_r, 16'd0}),
    .divisor  (big[31:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    tscale_nxt  = tscale_r;
    sf_nxt      = sf_r;
    ready_nxt   = ready_r;
    axis_nxt    = axis_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    sat_any_nxt = sat_any_r;
    stat_nxt    = stat_r;
    ov_nxt      = ov_r && out_stall;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    oz_nxt      = oz_r;
    ost_nxt     = ost_r;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      box_min_nxt[i] = box_min_r[i];
      box_max_nxt[i] = box_max_r[i];
      cur_nxt[i]     = cur_r[i];
      ext_nxt[i]     = ext_r[i];
      res_nxt[i]     = res_r[i];
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_st.empty) begin
          q_pop = 1'b1;
          case (head.op)
            OP_CLEAR: begin
              for (int i = 0; i < AXES; i++) begin
                box_min_nxt[i] = Q_MAX;
                box_max_nxt[i] = Q_MIN;
              end
              ready_nxt = 1'b0;
            end
            OP_MEASURE: begin
              for (int i = 0; i < AXES; i++) begin
                if (hc[i] < box_min_r[i]) begin
                  box_min_nxt[i] = hc[i];
                end
                if (hc[i] > box_max_r[i]) begin
                  box_max_nxt[i] = hc[i];
                end
              end
              ready_nxt = 1'b0;
            end
            OP_NORM: begin
              for (int i = 0; i < AXES; i++) begin
                cur_nxt[i] = hc[i];
              end
              sat_any_nxt = 1'b0;
              axis_nxt    = '0;
              state_nxt   = ready_r ? ST_DIFF : ST_EXT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXT: begin
        for (int i = 0; i < AXES; i++) begin
          ext_nxt[i] = $signed({box_max_r[i][COORD_W-1], box_max_r[i]})
                     - $signed({box_min_r[i][COORD_W-1], box_min_r[i]});
        end
        state_nxt = ST_BIG;
      end
      ST_BIG: begin
        if (big <= 0) begin
          // Empty or flat box: no factor, result is zero with its own status.
          for (int i = 0; i < AXES; i++) begin
            res_nxt[i] = '0;
          end
          stat_nxt  = STAT_DEGEN;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sf_nxt    = (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
          ready_nxt = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        neg_nxt   = diff[COORD_W+2];
        mag_nxt   = diff[COORD_W+2] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        plo_nxt   = {32'd0, mag_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, sf_r};
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        phi_nxt   = {32'd0, mag_r[MAG_W-1:HALF_W]} * {{HALF_W{1'b0}}, sf_r};
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        res_nxt[axis_r] = ax_val;
        sat_any_nxt     = sat_any_r || prod_sat;
        if (axis_r == AXIS_W'(AXES - 1)) begin
          stat_nxt  = (sat_any_r || prod_sat) ? STAT_SAT : STAT_OK;
          state_nxt = ST_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ox_nxt    = res_r[0];
          oy_nxt    = res_r[1];
          oz_nxt    = res_r[2];
          ost_nxt   = stat_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      tscale_nxt = cfg_target_scale;
      ready_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tscale_r <= TARGET_SCALE_RST;
      sf_r     <= '0;
      ready_r  <= 1'b0;
      ov_r     <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        box_min_r[i] <= Q_MAX;
        box_max_r[i] <= Q_MIN;
      end
    end else begin
      state_r  <= state_nxt;
      tscale_r <= tscale_nxt;
      sf_r     <= sf_nxt;
      ready_r  <= ready_nxt;
      ov_r     <= ov_nxt;
      for (int i = 0; i < AXES; i++) begin
        box_min_r[i] <= box_min_nxt[i];
        box_max_r[i] <= box_max_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    axis_r    <= axis_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    plo_r     <= plo_nxt;
    phi_r     <= phi_nxt;
    sat_any_r <= sat_any_nxt;
    stat_r    <= stat_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    oz_r      <= oz_nxt;
    ost_r     <= ost_nxt;
    for (int i = 0; i < AXES; i++) begin
      cur_r[i] <= cur_nxt[i];
      ext_r[i] <= ext_nxt[i];
      res_r[i] <= res_nxt[i];
    end
  end

  assign out_valid  = ov_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;
  assign out_status = ost_r;

endmodule

// ===== tb/point_cloud_box_normalizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_box_normalizer_test: self-checking bench for the box normalizer
// Drives clear, measure and normalize transactions with random idling and
// back pressure. A behavioral predictor keeps its own bounding box, scale
// factor and target scale, and every output transaction is compared field by
// field with the oldest predicted result.
// ----------------------------------------------------------------------------
module point_cloud_box_normalizer_test;
  import pcbn_pkg::*;

  // A normalize that recomputes the scale factor keeps the back end busy
  // longest, so SETTLE_CYCLES quiet cycles cover anything still in flight.
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int IDLE_PCT      = 11;

  // Saturation bounds widened to 64 bits for the predictor arithmetic.
  localparam longint SAT_HI = longint'(Q_MAX);
  localparam longint SAT_LO = longint'(Q_MIN);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [1:0]                status;
  } norm_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [31:0]               cfg_target_scale = TARGET_SCALE_RST;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_req_type = REQ_CLEAR;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic signed [COORD_W-1:0] in_z_coord = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [1:0]                out_status;

  point_cloud_box_normalizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_target_scale (cfg_target_scale),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_z_coord       (in_z_coord),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_status       (out_status)
  );

  // Predictor state: the box, the cached scale factor and the register copy.
  logic signed [COORD_W-1:0] box_lo [AXES];
  logic signed [COORD_W-1:0] box_hi [AXES];
  logic [31:0]               scale_q;
  bit                        scale_known;
  logic [31:0]               target_q;

  norm_result_t expected_points [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // When calm is set neither side idles; hold_req asks the receiver for one
  // long stall that it times on its own.
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // A hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void empty_box();
    for (int i = 0; i < AXES; i++) begin
      box_lo[i] = Q_MAX;
      box_hi[i] = Q_MIN;
    end
    scale_known = 1'b0;
  endfunction

  // Computes floor((2*coord - (lo + hi)) * factor / 2^17) with saturation.
  // The magnitude test guards against a product beyond 48 bits, where the
  // result is certain to saturate anyway.
  function automatic longint scale_coord(logic signed [COORD_W-1:0] c, longint sum,
                                         logic [31:0] factor, inout bit clamped);
    longint          d;
    longint          q;
    longint unsigned mag;
    longint unsigned f64;
    longint unsigned prod;
    d   = 2 * longint'(c) - sum;
    mag = (d < 0) ? -d : d;
    f64 = 64'(factor);
    if (f64 != 0 && mag > 64'h0000_FFFF_FFFF_FFFF / f64) begin
      clamped = 1'b1;
      return (d < 0) ? SAT_LO : SAT_HI;
    end
    prod = mag * f64;
    // Negative values round toward minus infinity, so the magnitude rounds up.
    if (d < 0)
      q = -longint'((prod + 64'h1FFFF) >> 17);
    else
      q = longint'(prod >> 17);
    if (q > SAT_HI) begin
      clamped = 1'b1;
      return SAT_HI;
    end
    if (q < SAT_LO) begin
      clamped = 1'b1;
      return SAT_LO;
    end
    return q;
  endfunction

  // Applies one accepted transaction to the predictor and queues the result
  // that it must produce, if any.
  function automatic void predict_item(logic [1:0] op, logic signed [COORD_W-1:0] px,
                                       logic signed [COORD_W-1:0] py,
                                       logic signed [COORD_W-1:0] pz);
    logic signed [COORD_W-1:0] pt [AXES];
    logic signed [COORD_W-1:0] lane [AXES];
    longint                    widest;
    longint                    ext;
    longint unsigned           quo;
    norm_result_t              res;
    bit                        clamped;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    case (op)
      REQ_CLEAR: empty_box();
      REQ_MEASURE: begin
        for (int i = 0; i < AXES; i++) begin
          if (pt[i] < box_lo[i]) box_lo[i] = pt[i];
          if (pt[i] > box_hi[i]) box_hi[i] = pt[i];
        end
        scale_known = 1'b0;
      end
      REQ_NORM: begin
        if (!scale_known) begin
          widest = longint'(box_hi[0]) - longint'(box_lo[0]);
          for (int i = 1; i < AXES; i++) begin
            ext = longint'(box_hi[i]) - longint'(box_lo[i]);
            if (ext > widest) widest = ext;
          end
          // An empty box or a single point leaves the factor unknown.
          if (widest <= 0) begin
            res.x      = '0;
            res.y      = '0;
            res.z      = '0;
            res.status = STAT_DEGEN;
            expected_points.push_back(res);
            return;
          end
          quo = {16'd0, target_q, 16'd0} / widest;
          scale_q = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
          scale_known = 1'b1;
        end
        clamped = 1'b0;
        for (int i = 0; i < AXES; i++)
          lane[i] = COORD_W'(scale_coord(pt[i], longint'(box_lo[i]) + longint'(box_hi[i]),
                                         scale_q, clamped));
        res.x      = lane[0];
        res.y      = lane[1];
        res.z      = lane[2];
        res.status = clamped ? STAT_SAT : STAT_OK;
        expected_points.push_back(res);
      end
      default: ;  // The reserved code is dropped without any effect.
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Samples the output channel at the rising edge, where the values driven
  // before the edge are still visible.
  always @(posedge clk) begin : check_results
    norm_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_points.size() == 0) begin
        report_mismatch("result with nothing pending", out_x, '0);
      end else begin
        want = expected_points.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_status !== want.status)
          report_mismatch("out_status", 32'(out_status), 32'(want.status));
      end
    end
  end

  // Receiver: random stalls about 11 percent of the time, none while calm,
  // and one long hold-off on request so the command queue fills up behind
  // the held output register.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one transaction, possibly after a few idle cycles, and returns at
  // the rising edge that accepted it. Valid stays high until the next falling
  // edge, where the next transaction or a drain takes over the input.
  task automatic send_point(input logic [1:0] op, input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic signed [COORD_W-1:0] pz);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_x_coord  <= px;
    in_y_coord  <= py;
    in_z_coord  <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, px, py, pz);
  endtask

  // Waits until every predicted result has arrived, then lets the block
  // finish any trailing clear or measure work.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_target_scale(input logic [31:0] value);
    drain_block();
    cfg_wr_en        <= 1'b1;
    cfg_target_scale <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    target_q    = value;
    scale_known = 1'b0;
  endtask

  // A value within 2^span of the middle, on either side.
  function automatic logic signed [COORD_W-1:0] near_point(logic signed [COORD_W-1:0] mid,
                                                           int span);
    logic [31:0] mask;
    logic [31:0] off;
    mask = (span >= 32) ? 32'hFFFF_FFFF : (32'd1 << span) - 32'd1;
    off  = $urandom & mask;
    return ($urandom_range(0, 1) != 0) ? mid + off : mid - off;
  endfunction

  // Normalize coordinates: mostly around the box, sometimes anywhere at all,
  // sometimes at the very ends of the range.
  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] mid,
                                                           int span);
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return $urandom;
      default: return near_point(mid, span + 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty boxes and single-point boxes must report a degenerate status, and
  // the reserved request code must leave no trace.
  task automatic test_degenerate_boxes();
    send_point(REQ_NORM, 32'sd100, -32'sd100, 32'sd0);
    send_point(REQ_RSVD, Q_MAX, Q_MIN, 32'sd1);
    send_point(REQ_MEASURE, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000);
    send_point(REQ_NORM, 32'sh0005_0000, 32'sh0006_0000, -32'sd1);
    send_point(REQ_CLEAR, 32'sd0, 32'sd0, 32'sd0);
    send_point(REQ_NORM, 32'sd1, 32'sd2, 32'sd3);
  endtask

  // The widest possible box, then the largest and smallest target scales.
  task automatic test_extreme_box();
    send_point(REQ_MEASURE, Q_MIN, Q_MIN, Q_MIN);
    send_point(REQ_MEASURE, Q_MAX, Q_MAX, Q_MAX);
    send_point(REQ_NORM, Q_MAX, Q_MAX, Q_MAX);
    send_point(REQ_NORM, Q_MIN, Q_MIN, Q_MIN);
    send_point(REQ_NORM, 32'sd0, -32'sd1, 32'sd1);
    write_target_scale(32'hFFFF_FFFF);
    send_point(REQ_NORM, Q_MIN, 32'sd0, Q_MAX);
    write_target_scale(32'd0);
    send_point(REQ_NORM, Q_MAX, Q_MIN, 32'sh1234_5678);
  endtask

  // A box one LSB wide with the largest target pushes the factor and the
  // products past every limit.
  task automatic test_saturation();
    write_target_scale(32'hFFFF_FFFF);
    send_point(REQ_CLEAR, Q_MAX, Q_MAX, Q_MAX);
    send_point(REQ_MEASURE, 32'sd0, 32'sd0, 32'sd0);
    send_point(REQ_MEASURE, 32'sd1, -32'sd1, 32'sd0);
    send_point(REQ_NORM, Q_MAX, Q_MIN, 32'sd0);
    send_point(REQ_NORM, 32'sd1, 32'sd0, -32'sd1);
  endtask

  // A measure between normalizes must force a new factor.
  task automatic test_recompute();
    write_target_scale(TARGET_SCALE_RST);
    send_point(REQ_CLEAR, 32'sd0, 32'sd0, 32'sd0);
    send_point(REQ_MEASURE, -32'sh0001_0000, 32'sh0002_0000, 32'sd0);
    send_point(REQ_MEASURE, 32'sh0001_0000, 32'sh0003_0000, 32'sh0000_8000);
    send_point(REQ_NORM, 32'sh0000_8000, 32'sh0002_8000, 32'sd0);
    send_point(REQ_MEASURE, 32'sh0010_0000, 32'sd0, -32'sh0010_0000);
    send_point(REQ_NORM, 32'sh0000_8000, 32'sh0002_8000, 32'sd0);
  endtask

  // Random clouds: mostly a clear, a handful of measures and a run of
  // normalizes, with the odd late measure; the rest is loose noise with any
  // request code. Reserved codes do not count toward the budget.
  task automatic test_random_clouds(input int budget);
    int                        sent;
    int                        span;
    logic [1:0]                op;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] mz;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19);
        if ($urandom_range(0, 1) != 0) begin
          mx = $urandom;
          my = $urandom;
          mz = $urandom;
        end else begin
          mx = near_point('0, 18);
          my = near_point('0, 18);
          mz = near_point('0, 18);
        end
        if ($urandom_range(0, 9) != 0) begin
          send_point(REQ_CLEAR, $urandom, $urandom, $urandom);
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_point(REQ_MEASURE, near_point(mx, span), near_point(my, span),
                     near_point(mz, span));
          sent++;
        end
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 19) == 0) begin
            send_point(REQ_MEASURE, near_point(mx, span + 1), near_point(my, span + 1),
                       near_point(mz, span + 1));
            sent++;
          end
          send_point(REQ_NORM, pick_coord(mx, span), pick_coord(my, span),
                     pick_coord(mz, span));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = 2'($urandom_range(0, 3));
          send_point(op, $urandom, $urandom, $urandom);
          if (op != REQ_RSVD) sent++;
        end
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_clouds(200);
    drain_block();
    calm = 1'b0;
  endtask

  // The receiver holds off for a long stretch while normalizes keep coming,
  // so the output register, the back end and the queue all fill.
  task automatic test_input_backpressure();
    send_point(REQ_CLEAR, 32'sd0, 32'sd0, 32'sd0);
    send_point(REQ_MEASURE, -32'sh0040_0000, 32'sd0, 32'sh0001_0000);
    send_point(REQ_MEASURE, 32'sh0040_0000, 32'sh0020_0000, -32'sh0001_0000);
    hold_req = 1'b1;
    repeat (30)
      send_point(REQ_NORM, near_point('0, 23), near_point('0, 23), near_point('0, 17));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    target_q = TARGET_SCALE_RST;
    scale_q  = '0;
    empty_box();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_degenerate_boxes();
    test_extreme_box();
    test_saturation();
    test_recompute();

    // Random phases, each under its own target scale.
    test_random_clouds(300);
    write_target_scale($urandom);
    test_random_clouds(250);
    write_target_scale(32'd1);
    test_random_clouds(150);
    write_target_scale(32'hFFFF_FFFF);
    test_random_clouds(200);
    write_target_scale(32'd0);
    test_random_clouds(80);
    write_target_scale($urandom_range(1, 32'h0100_0000));
    test_steady_stream();
    test_input_backpressure();
    write_target_scale(TARGET_SCALE_RST);
    test_random_clouds(250);

    drain_block();
    if (expected_points.size() != 0)
      report_mismatch("results never delivered", expected_points.size(), '0);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
